/* rtl/bottom_up_merge_sorter_unit_macros.svh */
// assertion macros for the merge sorter
`ifndef BOTTOM_UP_MERGE_SORTER_UNIT_MACROS_SVH
`define BOTTOM_UP_MERGE_SORTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BUMS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define BUMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bums_pkg.sv */
// shared types and constants of the merge sorter
package bums_pkg;

	localparam int DATA_W = 64;

	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_RUN,
		ST_READ,
		ST_MERGE,
		ST_OREAD,
		ST_OEMIT
	} state_t;

endpackage

/* rtl/bottom_up_merge_sorter_unit.sv */
// bottom-up merge sorter: load, ping-pong merge passes, sorted readout
//
// words are loaded one per cycle while busy is low: a word is taken at a rising edge with
// start high and busy low. words beyond MAX_ITEMS are dropped and flag overflow for the set.
// the word with last_in high ends the set; busy then rises and the block sorts the n kept
// words with a single shared comparator stepping over two memory banks used as ping-pong
// source and destination. each merged element takes a registered memory read, then
// compare and write back; every run has a setup step, every pass a pass setup and a pass
// close, and a last pass setup finds the sort done. each sorted word then takes a
// registered read before it leaves: strobe is high for exactly one cycle per word,
// last_out marks the final one and overflow is repeated on each. the receiver cannot
// hold results off, so it must take a word in every cycle that strobe is high. busy
// falls in the cycle after the last word.
// the banks need no clearing: only entries written for the current set are ever used.
`include "bottom_up_merge_sorter_unit_macros.svh"

module bottom_up_merge_sorter_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bums_pkg::DATA_W-1:0]   value,
	input  logic                          last_in,
	output logic                          strobe,
	output logic [bums_pkg::DATA_W-1:0]   sorted_value,
	output logic                          last_out,
	output logic                          overflow
);

	// address bits of a bank, bits of a count that can reach MAX_ITEMS
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	// run width stays below twice the set size; run bounds sum lo and 2*width
	localparam int WW = CW + 1;
	localparam int SW = CW + 2;

	bums_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;   // words kept in the current set
	logic          ovf_q;     // a word of this set was dropped
	logic          sel_q;     // bank holding the current source data
	logic [WW-1:0] w_q;       // run width of this pass
	logic [CW-1:0] lo_q;      // start of the current run pair
	logic [CW-1:0] mid_q;     // end of left run
	logic [CW-1:0] hi_q;      // end of right run
	logic [CW-1:0] a_q;       // left head, also readout index
	logic [CW-1:0] b_q;       // right head
	logic [CW-1:0] k_q;       // destination index

	bums_pkg::data_t rd0_a, rd0_b, rd1_a, rd1_b;
	bums_pkg::data_t src_a, src_b, pick;

	logic take_a;
	logic load_we, merge_we;
	logic we0, we1;
	logic [AW-1:0] waddr;
	bums_pkg::data_t wdata;
	logic accept, store_ok;

	logic [SW-1:0] sum_mid, sum_hi;
	logic [CW-1:0] run_mid, run_hi;
	logic [CW-1:0] k_inc, a_inc;

	assign accept   = start && (state_q == bums_pkg::ST_IDLE);
	assign store_ok = (count_q < CW'(MAX_ITEMS));

	// source bank read data
	assign src_a = sel_q ? rd1_a : rd0_a;
	assign src_b = sel_q ? rd1_b : rd0_b;

	// the shared comparator: left run wins on ties, an exhausted run never wins
	assign take_a = (b_q >= hi_q) || ((a_q < mid_q) && (src_a <= src_b));
	assign pick   = take_a ? src_a : src_b;

	// run bounds, clipped to the set size
	assign sum_mid = SW'(lo_q) + SW'(w_q);
	assign sum_hi  = SW'(lo_q) + SW'({w_q, 1'b0});
	assign run_mid = (sum_mid > SW'(count_q)) ? count_q : sum_mid[CW-1:0];
	assign run_hi  = (sum_hi  > SW'(count_q)) ? count_q : sum_hi[CW-1:0];

	assign k_inc = k_q + CW'(1);
	assign a_inc = a_q + CW'(1);

	// write routing: loads go to bank 0, merges to the bank that is not the source
	assign load_we  = accept && store_ok;
	assign merge_we = (state_q == bums_pkg::ST_MERGE);
	assign we0      = load_we || (merge_we && sel_q);
	assign we1      = merge_we && !sel_q;
	assign waddr    = load_we ? count_q[AW-1:0] : k_q[AW-1:0];
	assign wdata    = load_we ? value : pick;

	bums_ram #(.AW(AW)) u_bank0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (a_q[AW-1:0]),
		.raddr_b (b_q[AW-1:0]),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	bums_ram #(.AW(AW)) u_bank1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (a_q[AW-1:0]),
		.raddr_b (b_q[AW-1:0]),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bums_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		strobe   = 1'b0;
		unique case (state_q)
			bums_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && last_in) begin
					state_d = bums_pkg::ST_PASS;
				end
			end
			bums_pkg::ST_PASS: begin
				if (SW'(w_q) >= SW'(count_q)) begin
					state_d = bums_pkg::ST_OREAD;
				end else begin
					state_d = bums_pkg::ST_RUN;
				end
			end
			bums_pkg::ST_RUN: begin
				if (lo_q >= count_q) begin
					state_d = bums_pkg::ST_PASS;
				end else begin
					state_d = bums_pkg::ST_READ;
				end
			end
			bums_pkg::ST_READ: begin
				state_d = bums_pkg::ST_MERGE;
			end
			bums_pkg::ST_MERGE: begin
				if (k_inc == hi_q) begin
					state_d = bums_pkg::ST_RUN;
				end else begin
					state_d = bums_pkg::ST_READ;
				end
			end
			bums_pkg::ST_OREAD: begin
				state_d = bums_pkg::ST_OEMIT;
			end
			bums_pkg::ST_OEMIT: begin
				strobe = 1'b1;
				if (a_inc == count_q) begin
					state_d = bums_pkg::ST_IDLE;
				end else begin
					state_d = bums_pkg::ST_OREAD;
				end
			end
			default: begin
				state_d = bums_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sel_q   <= 1'b0;
			w_q     <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				bums_pkg::ST_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						sel_q <= 1'b0;
						w_q   <= WW'(1);
					end
				end
				bums_pkg::ST_PASS: begin
					lo_q <= '0;
					a_q  <= '0;
				end
				bums_pkg::ST_RUN: begin
					if (lo_q >= count_q) begin
						// pass done: merged data becomes the source
						sel_q <= !sel_q;
						w_q   <= {w_q[WW-2:0], 1'b0};
					end else begin
						mid_q <= run_mid;
						hi_q  <= run_hi;
						a_q   <= lo_q;
						b_q   <= run_mid;
						k_q   <= lo_q;
					end
				end
				bums_pkg::ST_READ: begin
				end
				bums_pkg::ST_MERGE: begin
					if (take_a) begin
						a_q <= a_inc;
					end else begin
						b_q <= b_q + CW'(1);
					end
					k_q <= k_inc;
					if (k_inc == hi_q) begin
						lo_q <= hi_q;
					end
				end
				bums_pkg::ST_OREAD: begin
				end
				bums_pkg::ST_OEMIT: begin
					a_q <= a_inc;
					if (a_inc == count_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sorted_value = src_a;
	assign last_out     = (a_inc == count_q);
	assign overflow     = ovf_q;

	`BUMS_ASSERT_SAME(a_count_cap, 1'b1, count_q <= CW'(MAX_ITEMS), "word count beyond capacity")
	`BUMS_ASSERT_SAME(a_merge_heads, state_q == bums_pkg::ST_MERGE, (k_q < hi_q) && (a_q <= mid_q) && (b_q <= hi_q) && (b_q >= mid_q), "merge heads out of run bounds")
	`BUMS_ASSERT_NEXT(a_last_ends, strobe && last_out, !busy && !strobe, "block still busy after final word")
	`BUMS_ASSERT_NEXT(a_word_gap, strobe, !strobe, "result words back to back")

endmodule

/* rtl/bums_ram.sv */
// one-write two-read memory bank with registered read data
module bums_ram #(
	parameter int AW = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bums_pkg::data_t wdata,
	input  logic [AW-1:0]   raddr_a,
	input  logic [AW-1:0]   raddr_b,
	output bums_pkg::data_t rdata_a,
	output bums_pkg::data_t rdata_b
);

	localparam int DEPTH = 1 << AW;

	bums_pkg::data_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* tb/sv/sorted_word_checker.sv */
// checker for the merge sorter: predicts each sorted set and compares the words
module sorted_word_checker #(
	parameter int SET_CAP = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [bums_pkg::DATA_W-1:0] value,
	input  logic                        last_in,
	input  logic                        strobe,
	input  logic [bums_pkg::DATA_W-1:0] sorted_value,
	input  logic                        last_out,
	input  logic                        overflow,
	output int                          mismatches,
	output int                          outstanding
);

	typedef struct packed {
		bums_pkg::data_t word;
		logic            tail;
		logic            dropped;
	} sorted_word_t;

	sorted_word_t    due_q[$];
	sorted_word_t    due;
	bums_pkg::data_t set_words[SET_CAP];
	bums_pkg::data_t merge_tmp[SET_CAP];
	int              set_len;
	logic            set_dropped;

	// bottom-up merge over set_words, left run wins on equal words
	function automatic void sort_set_words(input int n);
		int w, lo, mid, hi, a, b, k;
		for (w = 1; w < n; w = w * 2) begin
			for (lo = 0; lo < n; lo = lo + 2 * w) begin
				mid = (lo + w > n) ? n : lo + w;
				hi = (lo + 2 * w > n) ? n : lo + 2 * w;
				a = lo;
				b = mid;
				for (k = lo; k < hi; k++) begin
					if (b >= hi || (a < mid && set_words[a] <= set_words[b])) begin
						merge_tmp[k] = set_words[a];
						a++;
					end else begin
						merge_tmp[k] = set_words[b];
						b++;
					end
				end
			end
			for (k = 0; k < n; k++)
				set_words[k] = merge_tmp[k];
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q.delete();
			set_len = 0;
			set_dropped = 1'b0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// outgoing word first, so a word never meets the set being loaded
			if (strobe) begin
				if (due_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected sorted word %h last %b overflow %b",
							sorted_value, last_out, overflow);
					mismatches++;
				end else begin
					due = due_q.pop_front();
					if (sorted_value !== due.word || last_out !== due.tail ||
							overflow !== due.dropped) begin
						if (mismatches < 10)
							$display("sorted word: expected %h last %b overflow %b, got %h last %b overflow %b",
								due.word, due.tail, due.dropped,
								sorted_value, last_out, overflow);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				if (set_len < SET_CAP) begin
					set_words[set_len] = value;
					set_len++;
				end else begin
					set_dropped = 1'b1;
				end
				if (last_in) begin
					sort_set_words(set_len);
					for (int i = 0; i < set_len; i++) begin
						due.word = set_words[i];
						due.tail = (i == set_len - 1);
						due.dropped = set_dropped;
						due_q.push_back(due);
					end
					set_len = 0;
					set_dropped = 1'b0;
				end
			end
			outstanding <= due_q.size();
		end
	end

endmodule

/* tb/sv/bottom_up_merge_sorter_unit_test.sv */
// top of the merge sorter bench: clock, reset, set stimulus and verdict
module bottom_up_merge_sorter_unit_test;

	localparam int SET_CAP    = 64;
	localparam int RANDOM_WORDS = 150;
	// far beyond the slowest legal run of all sets, gaps included
	localparam int LIMIT_CYCLES = 200000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	bums_pkg::data_t value;
	logic  last_in;
	logic  strobe;
	bums_pkg::data_t sorted_value;
	logic  last_out;
	logic  overflow;

	int    mismatches;
	int    outstanding;
	// while set, the sender never idles
	bit    calm;

	bottom_up_merge_sorter_unit #(
		.MAX_ITEMS(SET_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last_in(last_in),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflow(overflow)
	);

	sorted_word_checker #(
		.SET_CAP(SET_CAP)
	) sorter_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last_in(last_in),
		.strobe(strobe),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflow(overflow),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// random word: mostly full width, some from a tiny pool to force ties,
	// some at the ends of the range
	function automatic bums_pkg::data_t pick_word();
		int r;
		bums_pkg::data_t w;
		r = $urandom_range(5);
		if (r < 3) begin
			w = {$urandom, $urandom};
		end else if (r < 5) begin
			w = bums_pkg::data_t'($urandom_range(3));
		end else begin
			case ($urandom_range(3))
				0: w = '0;
				1: w = '1;
				2: w = {1'b1, 63'd0};
				default: w = {1'b0, {63{1'b1}}};
			endcase
		end
		return w;
	endfunction

	// present one word and hold it until taken; returns on the accepting edge
	// with start still high, so the next call can keep it high
	task automatic send_word(input bums_pkg::data_t w, input logic tail);
		// idle cycle by cycle with junk on the data lines, last_in included
		while (!calm && $urandom_range(99) < 37) begin
			start <= 1'b0;
			value <= {$urandom, $urandom};
			last_in <= 1'($urandom_range(1));
			@(posedge clk);
		end
		start <= 1'b1;
		value <= w;
		last_in <= tail;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// hold off until every sorted word of the sets sent so far is back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
	endtask

	initial begin
		int k;
		int set_no;
		int set_size;
		int random_sent;

		arst_n <= 1'b0;
		start <= 1'b0;
		value <= '0;
		last_in <= 1'b0;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-word sets at both ends of the range
		send_word('0, 1'b1);
		send_word('1, 1'b1);
		// extremes with duplicates, odd size so the last run is short
		send_word('1, 1'b0);
		send_word('0, 1'b0);
		send_word({1'b1, 63'd0}, 1'b0);
		send_word(64'd1, 1'b0);
		send_word({1'b0, {63{1'b1}}}, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b1);
		// already in order
		for (k = 1; k <= 4; k++)
			send_word(bums_pkg::data_t'(k), k == 4);
		// reverse order, high bits only
		for (k = 5; k >= 1; k--)
			send_word(bums_pkg::data_t'(k) << 59, k == 1);
		// all equal
		for (k = 1; k <= 3; k++)
			send_word(64'ha5a5_5a5a_a5a5_5a5a, k == 3);
		wait_drained();

		// random sets: mostly short, one filling the store exactly,
		// one running past it so the closing word itself is dropped
		random_sent = 0;
		set_no = 0;
		while (random_sent < RANDOM_WORDS) begin
			if (set_no == 1)
				set_size = SET_CAP;
			else if (set_no == 4)
				set_size = SET_CAP + $urandom_range(1, 6);
			else if ($urandom_range(5) == 0)
				set_size = $urandom_range(11, 24);
			else
				set_size = $urandom_range(1, 10);
			for (k = 1; k <= set_size; k++) begin
				calm = (random_sent >= 40 && random_sent < 110);
				send_word(pick_word(), k == set_size);
				random_sent++;
			end
			// sometimes let the whole pipe empty before the next set
			if (set_no == 2 || $urandom_range(4) == 0)
				wait_drained();
			set_no++;
		end

		// drain, then a quiet tail to catch stray words
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hang guard
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bums_pkg.sv
rtl/bums_ram.sv
rtl/bottom_up_merge_sorter_unit.sv
tb/sv/sorted_word_checker.sv
tb/sv/bottom_up_merge_sorter_unit_test.sv
